FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle, outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// implication checked in the next cycle, reset included
`define ASSERT_NEXT_ALL(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/anps_pkg.sv
package anps_pkg;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_t;

  localparam logic [1:0] POWER_OK     = 2'd2;
  localparam logic [7:0] BASE_BYTE    = 8'h40;
  localparam logic [7:0] FORCED_BYTE  = 8'hFF;
  localparam logic [6:0] SEQ_LIMIT    = 7'd32;
  localparam logic [6:0] SEQ_STEP     = 7'd8;

  // nibble select codes
  localparam logic [3:0] SEL_BTN_LO = 4'd0;
  localparam logic [3:0] SEL_BTN_HI = 4'd1;
  localparam logic [3:0] SEL_X_HI   = 4'd2;
  localparam logic [3:0] SEL_Y_HI   = 4'd3;
  localparam logic [3:0] SEL_Z_HI   = 4'd5;
  localparam logic [3:0] SEL_X_LO   = 4'd6;
  localparam logic [3:0] SEL_Y_LO   = 4'd7;
  localparam logic [3:0] SEL_Z_LO   = 4'd9;

  typedef struct packed {
    logic       prev_th;
    logic [5:0] seq_counter;
    logic [1:0] read_latency;
    logic [7:0] data_reg;
  } state_t;

  typedef struct packed {
    req_t       req_type;
    logic       th_level;
    logic [7:0] buttons;
    logic [7:0] axis_x;
    logic [7:0] axis_y;
    logic [7:0] axis_z;
  } item_t;

  localparam state_t STATE_RESET = '{
    prev_th:      1'b1,
    seq_counter:  6'd0,
    read_latency: 2'd0,
    data_reg:     8'hFF
  };

endpackage

FILE: hw/rtl/analog_pad_nibble_sequencer.sv
// channel  | handshake          | payload
// ---------+--------------------+---------------------------------------------
// in       | in_valid/in_stall  | req_type th_level buttons axis_x/y/z
// out      | out_valid/out_stall| port_data
// cfg      | cfg_wr_en          | cfg_wr_data (power_pin_state)
//
// one item per cycle sustained while out_stall is low; an item taken into
// the input register moves into the result register, showing on out_valid,
// and the pad state is updated as it moves into the result register
// rst is synchronous: both registers empty, pad state and power pins restored
// out_stall holds the result register and, while both registers are full,
// stalls the input
module analog_pad_nibble_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic       th_level,
  input  logic [7:0] buttons,
  input  logic [7:0] axis_x,
  input  logic [7:0] axis_y,
  input  logic [7:0] axis_z,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] port_data
);

  logic [1:0]        power_pins;
  logic              item_valid;
  anps_pkg::item_t   item;
  anps_pkg::state_t  state;
  anps_pkg::state_t  state_next;
  logic              advance;
  logic              accept;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = item_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      power_pins <= anps_pkg::POWER_OK;
    end else if (cfg_wr_en) begin
      power_pins <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= '{req_type: anps_pkg::req_t'(req_type), th_level: th_level,
                buttons: buttons, axis_x: axis_x, axis_y: axis_y, axis_z: axis_z};
    end
  end

  anps_step u_step (
    .cur             (state),
    .item            (item),
    .power_pin_state (power_pins),
    .nxt             (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= anps_pkg::STATE_RESET;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
      if (item_valid) begin
        state <= state_next;
      end
    end
  end

  assign port_data = state.data_reg;

endmodule

FILE: hw/rtl/anps_step.sv
module anps_step (
  input  anps_pkg::state_t cur,
  input  anps_pkg::item_t  item,
  input  logic [1:0]       power_pin_state,
  output anps_pkg::state_t nxt
);

  logic [6:0]  seq_bump;
  logic [5:0]  seq_read;
  logic        do_read;
  logic [2:0]  cyc;
  logic [3:0]  nib;
  logic [7:0]  rd_byte;

  // sequence advance on a write, saturating
  always_comb begin
    seq_bump = {1'b0, cur.seq_counter[5:3], 3'b000} + anps_pkg::SEQ_STEP;
    if (seq_bump > anps_pkg::SEQ_LIMIT) begin
      seq_bump = anps_pkg::SEQ_LIMIT;
    end
  end

  always_comb begin
    do_read  = 1'b0;
    seq_read = cur.seq_counter;
    nxt      = cur;
    if (item.req_type == anps_pkg::REQ_READ) begin
      do_read = 1'b1;
    end else begin
      nxt.prev_th = item.th_level;
      if (power_pin_state != anps_pkg::POWER_OK) begin
        nxt.data_reg = anps_pkg::FORCED_BYTE;
      end else if (cur.prev_th && !item.th_level) begin
        nxt.seq_counter  = 6'd0;
        nxt.read_latency = 2'd0;
      end else if (cur.read_latency > 2'd2) begin
        seq_read = seq_bump[5:0];
        do_read  = 1'b1;
      end
    end

    cyc = seq_read[2:0];
    case (seq_read[5:2])
      anps_pkg::SEL_BTN_LO: nib = item.buttons[3:0];
      anps_pkg::SEL_BTN_HI: nib = item.buttons[7:4];
      anps_pkg::SEL_X_HI:   nib = item.axis_x[7:4];
      anps_pkg::SEL_Y_HI:   nib = item.axis_y[7:4];
      anps_pkg::SEL_Z_HI:   nib = item.axis_z[7:4];
      anps_pkg::SEL_X_LO:   nib = item.axis_x[3:0];
      anps_pkg::SEL_Y_LO:   nib = item.axis_y[3:0];
      anps_pkg::SEL_Z_LO:   nib = item.axis_z[3:0];
      default:              nib = 4'h0;
    endcase
    rd_byte = anps_pkg::BASE_BYTE | {2'b00, (cyc[1:0] == 2'b00), cyc[2], nib};

    if (do_read) begin
      nxt.data_reg    = rd_byte;
      nxt.seq_counter = {seq_read[5:3], cyc + 3'd1};
      if (cur.read_latency != 2'd3) begin
        nxt.read_latency = cur.read_latency + 2'd1;
      end
    end
  end

endmodule

FILE: hw/rtl/anps_checker.sv
`include "assert_macros.svh"

module anps_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] port_data
);

  `ASSERT_NEXT_ALL(a_reset_empty, clk, rst, !out_valid, "result shown right after reset")
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(port_data), "stalled item changed")
  `ASSERT_IMP(a_base_bit, clk, rst, out_valid, port_data[6], "port byte lacks base bit")
  `ASSERT_IMP(a_forced, clk, rst, out_valid && port_data[7], port_data == 8'hFF, "bad forced byte")

endmodule

bind analog_pad_nibble_sequencer anps_checker u_anps_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .port_data (port_data)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_ITEMS = 190;

  typedef struct {
    logic            cfg_wr;
    logic [1:0]      cfg_val;
    anps_pkg::item_t req;
    logic            typed;
    logic [7:0]      byte_exp;
  } pad_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = anps_pkg::POWER_OK;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       req_type = 1'b0;
  logic       th_level = 1'b1;
  logic [7:0] buttons = 8'h00;
  logic [7:0] axis_x = 8'h80;
  logic [7:0] axis_y = 8'h80;
  logic [7:0] axis_z = 8'h80;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] port_data;

  analog_pad_nibble_sequencer dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .th_level(th_level),
    .buttons(buttons),
    .axis_x(axis_x),
    .axis_y(axis_y),
    .axis_z(axis_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .port_data(port_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // pad model state
  logic [1:0]       pins_cfg = anps_pkg::POWER_OK;
  anps_pkg::state_t pad = anps_pkg::STATE_RESET;

  logic [7:0] port_bytes[$];
  int         errors = 0;
  int         quiet_cycles = 0;
  bit         gaps_on = 1'b0;
  bit         stall_on = 1'b0;
  int         stall_left = 0;

  pad_row_t dir_rows [24] = '{
    '{1'b0, 2'd0, '{anps_pkg::REQ_READ,  1'b0, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h65},
    '{1'b0, 2'd0, '{anps_pkg::REQ_READ,  1'b1, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h45},
    '{1'b0, 2'd0, '{anps_pkg::REQ_WRITE, 1'b1, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h45},
    '{1'b0, 2'd0, '{anps_pkg::REQ_READ,  1'b0, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h45},
    '{1'b0, 2'd0, '{anps_pkg::REQ_READ,  1'b0, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h45},
    '{1'b0, 2'd0, '{anps_pkg::REQ_READ,  1'b0, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h7A},
    '{1'b0, 2'd0, '{anps_pkg::REQ_WRITE, 1'b1, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h6F},
    '{1'b0, 2'd0, '{anps_pkg::REQ_WRITE, 1'b1, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h60},
    '{1'b0, 2'd0, '{anps_pkg::REQ_WRITE, 1'b1, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h6F},
    '{1'b0, 2'd0, '{anps_pkg::REQ_WRITE, 1'b1, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h60},
    '{1'b0, 2'd0, '{anps_pkg::REQ_READ,  1'b0, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h40},
    '{1'b0, 2'd0, '{anps_pkg::REQ_READ,  1'b0, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h40},
    '{1'b0, 2'd0, '{anps_pkg::REQ_READ,  1'b0, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h40},
    '{1'b0, 2'd0, '{anps_pkg::REQ_READ,  1'b0, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h7A},
    '{1'b0, 2'd0, '{anps_pkg::REQ_WRITE, 1'b1, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h60},
    '{1'b0, 2'd0, '{anps_pkg::REQ_WRITE, 1'b0, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h60},
    '{1'b0, 2'd0, '{anps_pkg::REQ_WRITE, 1'b0, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h60},
    '{1'b0, 2'd0, '{anps_pkg::REQ_WRITE, 1'b1, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'h60},
    '{1'b1, 2'd0, '{anps_pkg::REQ_WRITE, 1'b1, 8'hA5, 8'hFF, 8'h00, 8'h5A}, 1'b1, 8'hFF},
    '{1'b0, 2'd0, '{anps_pkg::REQ_READ,  1'b1, 8'h3C, 8'h00, 8'hFF, 8'hA5}, 1'b0, 8'h00},
    '{1'b0, 2'd0, '{anps_pkg::REQ_WRITE, 1'b0, 8'h3C, 8'h00, 8'hFF, 8'hA5}, 1'b1, 8'hFF},
    '{1'b1, 2'd3, '{anps_pkg::REQ_WRITE, 1'b1, 8'h3C, 8'h00, 8'hFF, 8'hA5}, 1'b1, 8'hFF},
    '{1'b1, 2'd2, '{anps_pkg::REQ_READ,  1'b0, 8'h3C, 8'h00, 8'hFF, 8'hA5}, 1'b0, 8'h00},
    '{1'b1, 2'd1, '{anps_pkg::REQ_WRITE, 1'b0, 8'hC3, 8'h0F, 8'hF0, 8'h00}, 1'b1, 8'hFF}
  };

  logic [1:0] pin_plan [8] = '{2'd2, 2'd0, 2'd2, 2'd3, 2'd2, 2'd1, 2'd2, 2'd2};

  function automatic void pad_read(input anps_pkg::item_t a);
    logic [2:0] cyc;
    logic [3:0] nib;
    cyc = pad.seq_counter[2:0];
    case (pad.seq_counter[5:2])
      anps_pkg::SEL_BTN_LO: nib = a.buttons[3:0];
      anps_pkg::SEL_BTN_HI: nib = a.buttons[7:4];
      anps_pkg::SEL_X_HI:   nib = a.axis_x[7:4];
      anps_pkg::SEL_Y_HI:   nib = a.axis_y[7:4];
      anps_pkg::SEL_Z_HI:   nib = a.axis_z[7:4];
      anps_pkg::SEL_X_LO:   nib = a.axis_x[3:0];
      anps_pkg::SEL_Y_LO:   nib = a.axis_y[3:0];
      anps_pkg::SEL_Z_LO:   nib = a.axis_z[3:0];
      default:              nib = 4'd0;
    endcase
    pad.data_reg = anps_pkg::BASE_BYTE | {2'b00, cyc[1:0] == 2'b00, cyc[2], nib};
    pad.seq_counter = {pad.seq_counter[5:3], cyc + 3'd1};
    if (pad.read_latency != 2'd3) pad.read_latency = pad.read_latency + 2'd1;
  endfunction

  function automatic logic [7:0] pad_access(input anps_pkg::item_t a);
    logic       was_high;
    logic [6:0] next_seq;
    if (a.req_type == anps_pkg::REQ_READ) begin
      pad_read(a);
    end else begin
      was_high = pad.prev_th;
      pad.prev_th = a.th_level;
      if (pins_cfg != anps_pkg::POWER_OK) begin
        pad.data_reg = anps_pkg::FORCED_BYTE;
      end else if (was_high && !a.th_level) begin
        pad.seq_counter = 6'd0;
        pad.read_latency = 2'd0;
      end else if (pad.read_latency > 2'd2) begin
        next_seq = {1'b0, pad.seq_counter[5:3], 3'b000} + anps_pkg::SEQ_STEP;
        if (next_seq > anps_pkg::SEQ_LIMIT) next_seq = anps_pkg::SEQ_LIMIT;
        pad.seq_counter = next_seq[5:0];
        pad_read(a);
      end
    end
    return pad.data_reg;
  endfunction

  function automatic anps_pkg::item_t rand_access();
    anps_pkg::item_t a;
    a.req_type = ($urandom_range(0, 99) < 55) ? anps_pkg::REQ_READ : anps_pkg::REQ_WRITE;
    // mostly high TH on writes so sequences advance, occasional falling edge restarts
    if (a.req_type == anps_pkg::REQ_WRITE) a.th_level = ($urandom_range(0, 7) != 0);
    else a.th_level = 1'($urandom);
    a.buttons = 8'($urandom);
    a.axis_x = 8'($urandom);
    a.axis_y = 8'($urandom);
    a.axis_z = 8'($urandom);
    return a;
  endfunction

  task automatic send_access(input anps_pkg::item_t a, input logic typed,
                             input logic [7:0] want);
    logic [7:0] got;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= a.req_type;
    th_level <= a.th_level;
    buttons <= a.buttons;
    axis_x <= a.axis_x;
    axis_y <= a.axis_y;
    axis_z <= a.axis_z;
    do @(posedge clk); while (in_stall);
    got = pad_access(a);
    port_bytes.push_back(typed ? want : got);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (port_bytes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_pins(input logic [1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pins_cfg = v;
  endtask

  // receiver stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (port_bytes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected port byte %h", port_data);
      end else if (port_data !== port_bytes[0]) begin
        errors++;
        if (errors <= 10) $display("port_data mismatch: expected %h, got %h",
                                   port_bytes[0], port_data);
        void'(port_bytes.pop_front());
      end else begin
        void'(port_bytes.pop_front());
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    pad = anps_pkg::STATE_RESET;
    pins_cfg = anps_pkg::POWER_OK;
    gaps_on = 1'b1;
    stall_on = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_wr) begin
        drain();
        write_pins(dir_rows[i].cfg_val);
      end
      send_access(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].byte_exp);
    end

    foreach (pin_plan[p]) begin
      drain();
      write_pins(pin_plan[p]);
      // one phase mid-run without idle gaps or receiver stalls, and neither in the last phase
      gaps_on = (p != 3) && (p != 7);
      stall_on = (p != 3) && (p != 7);
      repeat (PHASE_ITEMS) send_access(rand_access(), 1'b0, 8'h00);
    end

    in_valid <= 1'b0;
    while (port_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0 && port_bytes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/anps_pkg.sv
hw/rtl/anps_step.sv
hw/rtl/analog_pad_nibble_sequencer.sv
hw/rtl/anps_checker.sv
tb/testbench.sv
